### hdl/arpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpe_pkg
// Shared constants, operation codes, the squared-cosine threshold table and
// the control/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package arpe_pkg;

    localparam int MAX_RINGS_DEF   = 64;
    localparam int COORD_WIDTH_DEF = 18;

    localparam int DIST_W     = 34;
    localparam int BINS_W     = 64;
    localparam int WORD_W     = 16;
    localparam int ENERGY_W   = 27;
    localparam int PAIRS_W    = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int CTHR_W     = 32;
    localparam int OP_W       = 4;
    localparam int BIN_W      = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIST      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BINS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BINS_HIGH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_LAST  = 2'd3;

    // multiplier operations of the angle test
    localparam logic [OP_W-1:0] OP_DOT_X = 4'd0;
    localparam logic [OP_W-1:0] OP_DOT_Y = 4'd1;
    localparam logic [OP_W-1:0] OP_DOT_Z = 4'd2;
    localparam logic [OP_W-1:0] OP_NA_X  = 4'd3;
    localparam logic [OP_W-1:0] OP_NA_Y  = 4'd4;
    localparam logic [OP_W-1:0] OP_NA_Z  = 4'd5;
    localparam logic [OP_W-1:0] OP_NB_X  = 4'd6;
    localparam logic [OP_W-1:0] OP_NB_Y  = 4'd7;
    localparam logic [OP_W-1:0] OP_NB_Z  = 4'd8;
    localparam logic [OP_W-1:0] OP_P     = 4'd9;
    localparam logic [OP_W-1:0] OP_D     = 4'd10;
    localparam logic [OP_W-1:0] OP_C     = 4'd11;

    localparam logic [BIN_W-1:0] BIN_FIRST = 4'd1;
    localparam logic [BIN_W-1:0] BIN_MAX   = 4'd8;

    // axis select for the cross product
    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    // round(cos^2(10k deg) * 2^32)
    function automatic logic [CTHR_W-1:0] cos2_thr(input logic [BIN_W-1:0] k);
        logic [CTHR_W-1:0] v;
        case (k)
            4'd1:    v = 32'd4165458185;
            4'd2:    v = 32'd3792551563;
            4'd3:    v = 32'd3221225472;
            4'd4:    v = 32'd2520390270;
            4'd5:    v = 32'd1774577026;
            4'd6:    v = 32'd1073741824;
            4'd7:    v = 32'd502415733;
            4'd8:    v = 32'd129509111;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    typedef struct packed {
        logic            accept;
        logic            mul_en;
        logic [1:0]      mul_sel;
        logic            sub_en;
        logic [1:0]      sub_sel;
        logic            store;
        logic            walk_init;
        logic            rd_en;
        logic            rd_second;
        logic            latch_a;
        logic            latch_b;
        logic            diff;
        logic            square;
        logic            dsum;
        logic            mul_start;
        logic            mul_take;
        logic [OP_W-1:0] op;
        logic            add_pair;
        logic            next_pair;
        logic            emit;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic few;
        logic close;
        logic mul_done;
        logic p_zero;
        logic cmp_le;
        logic k_last;
        logic pair_last;
        logic out_free;
    } t_sts;

endpackage

### hdl/arpe_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpe_mul
// Shift-and-add unsigned multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module arpe_mul #(
    parameter int PR_W = 192,
    parameter int B_W  = 80
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [PR_W-1:0] i_a,
    input  logic [B_W-1:0]  i_b,
    output logic            o_done,
    output logic [PR_W-1:0] o_prod
);
    localparam int CNT_W = $clog2(B_W);

    logic [PR_W-1:0]  r_a;
    logic [B_W-1:0]   r_b;
    logic [PR_W-1:0]  r_prod;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic             w_last;

    assign w_last = (r_cnt == CNT_W'(B_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && w_last;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && w_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a    <= i_a;
            r_b    <= i_b;
            r_prod <= '0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_prod <= r_prod + r_a;
            end
            r_a   <= r_a << 1;
            r_b   <= r_b >> 1;
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;
endmodule

### hdl/arpe_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpe_dp
// Datapath: ring geometry, ring store, pair distance, angle binning through
// the shared multiplier, energy accumulation, config and result registers.
// ----------------------------------------------------------------------------
module arpe_dp #(
    parameter int MAX_RINGS   = arpe_pkg::MAX_RINGS_DEF,
    parameter int COORD_WIDTH = arpe_pkg::COORD_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  arpe_pkg::t_cmd                         i_cmd,
    output arpe_pkg::t_sts                         o_sts,
    input  logic signed [COORD_WIDTH-1:0]          i_base_x,
    input  logic signed [COORD_WIDTH-1:0]          i_base_y,
    input  logic signed [COORD_WIDTH-1:0]          i_base_z,
    input  logic signed [COORD_WIDTH-1:0]          i_second_x,
    input  logic signed [COORD_WIDTH-1:0]          i_second_y,
    input  logic signed [COORD_WIDTH-1:0]          i_second_z,
    input  logic signed [COORD_WIDTH-1:0]          i_third_x,
    input  logic signed [COORD_WIDTH-1:0]          i_third_y,
    input  logic signed [COORD_WIDTH-1:0]          i_third_z,
    input  logic                                   i_last_ring,
    input  logic                                   i_out_stall,
    output logic                                   o_out_valid,
    output logic signed [arpe_pkg::ENERGY_W-1:0]   o_energy_milli,
    output logic [arpe_pkg::PAIRS_W-1:0]           o_close_pairs,
    input  logic                                   i_cfg_we,
    input  logic [arpe_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [arpe_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    localparam int W     = COORD_WIDTH;
    localparam int DU    = W + 1;
    localparam int CS_W  = W + 2;
    localparam int CD_W  = W + 3;
    localparam int N_W   = 2 * DU + 1;
    localparam int SQ_W  = 2 * CD_W;
    localparam int D2_W  = 2 * W + 6;
    localparam int LIM_W = arpe_pkg::DIST_W + 4;
    localparam int CMP_W = (D2_W > LIM_W) ? D2_W : LIM_W;
    localparam int DT_W  = 2 * N_W + 2;
    localparam int P_W   = 2 * DT_W;
    localparam int PR_W  = P_W + arpe_pkg::CTHR_W;
    localparam int AW    = (MAX_RINGS > 1) ? $clog2(MAX_RINGS) : 1;
    localparam int CW    = $clog2(MAX_RINGS + 1);
    localparam int ENT_W = 3 * CS_W + 3 * N_W;
    localparam int EW    = arpe_pkg::ENERGY_W;
    localparam int WW    = arpe_pkg::WORD_W;

    // config
    logic [arpe_pkg::DIST_W-1:0] r_dist;
    logic [arpe_pkg::BINS_W-1:0] r_bins_low;
    logic [arpe_pkg::BINS_W-1:0] r_bins_high;
    logic [WW-1:0]               r_bin_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist      <= arpe_pkg::DIST_W'(2768896);
            r_bins_low  <= '0;
            r_bins_high <= '0;
            r_bin_last  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                arpe_pkg::CFG_DIST:      r_dist      <= i_cfg_data[arpe_pkg::DIST_W-1:0];
                arpe_pkg::CFG_BINS_LOW:  r_bins_low  <= i_cfg_data;
                arpe_pkg::CFG_BINS_HIGH: r_bins_high <= i_cfg_data;
                arpe_pkg::CFG_BIN_LAST:  r_bin_last  <= i_cfg_data[WW-1:0];
                default: ;
            endcase
        end
    end

    // ring load
    logic signed [W-1:0]      w_base [3];
    logic signed [W-1:0]      w_sec  [3];
    logic signed [W-1:0]      w_thr  [3];
    logic signed [DU-1:0]     r_u    [3];
    logic signed [DU-1:0]     r_v    [3];
    logic signed [CS_W-1:0]   r_cs   [3];
    logic                     r_last;
    logic signed [DU-1:0]     w_m0, w_m1, w_m2, w_m3;
    logic signed [2*DU-1:0]   r_pa, r_pb;
    logic signed [N_W-1:0]    r_n    [3];

    assign w_base = '{i_base_x, i_base_y, i_base_z};
    assign w_sec  = '{i_second_x, i_second_y, i_second_z};
    assign w_thr  = '{i_third_x, i_third_y, i_third_z};

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            for (int i = 0; i < 3; i++) begin
                r_u[i]  <= DU'(w_sec[i]) - DU'(w_base[i]);
                r_v[i]  <= DU'(w_thr[i]) - DU'(w_base[i]);
                r_cs[i] <= CS_W'(w_base[i]) + CS_W'(w_sec[i]) + CS_W'(w_thr[i]);
            end
            r_last <= i_last_ring;
        end
    end

    always_comb begin
        case (i_cmd.mul_sel)
            arpe_pkg::AX_X: begin
                w_m0 = r_u[1]; w_m1 = r_v[2]; w_m2 = r_u[2]; w_m3 = r_v[1];
            end
            arpe_pkg::AX_Y: begin
                w_m0 = r_u[2]; w_m1 = r_v[0]; w_m2 = r_u[0]; w_m3 = r_v[2];
            end
            default: begin
                w_m0 = r_u[0]; w_m1 = r_v[1]; w_m2 = r_u[1]; w_m3 = r_v[0];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_pa <= w_m0 * w_m1;
            r_pb <= w_m2 * w_m3;
        end
        if (i_cmd.sub_en) begin
            r_n[i_cmd.sub_sel] <= N_W'(r_pa) - N_W'(r_pb);
        end
    end

    // ring store and pair counters
    logic [ENT_W-1:0] r_mem [MAX_RINGS];
    logic [ENT_W-1:0] r_rd;
    logic [CW-1:0]    r_cnt;
    logic [AW-1:0]    r_r1, r_r2;
    logic             w_full;

    assign w_full = (r_cnt == CW'(MAX_RINGS));

    always_ff @(posedge i_clk) begin
        if (i_cmd.store && !w_full) begin
            r_mem[r_cnt[AW-1:0]] <= {r_n[2], r_n[1], r_n[0], r_cs[2], r_cs[1], r_cs[0]};
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[i_cmd.rd_second ? r_r2 : r_r1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.emit) begin
            r_cnt <= '0;
        end else if (i_cmd.store && !w_full) begin
            r_cnt <= r_cnt + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_init) begin
            r_r1 <= '0;
            r_r2 <= AW'(1);
        end else if (i_cmd.next_pair) begin
            if (CW'(r_r2) + CW'(1) == r_cnt) begin
                r_r1 <= r_r1 + AW'(1);
                r_r2 <= AW'(CW'(r_r1) + CW'(2));
            end else begin
                r_r2 <= r_r2 + AW'(1);
            end
        end
    end

    // pair distance
    logic signed [CS_W-1:0] r_ca [3];
    logic signed [CS_W-1:0] r_cb [3];
    logic signed [N_W-1:0]  r_na [3];
    logic signed [N_W-1:0]  r_nb [3];
    logic signed [CD_W-1:0] r_cd [3];
    logic signed [SQ_W-1:0] r_sq [3];
    logic [D2_W-1:0]        r_d2;
    logic [LIM_W-1:0]       w_lim9;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (i_cmd.latch_a) begin
                r_ca[i] <= r_rd[i*CS_W +: CS_W];
                r_na[i] <= r_rd[3*CS_W + i*N_W +: N_W];
            end
            if (i_cmd.latch_b) begin
                r_cb[i] <= r_rd[i*CS_W +: CS_W];
                r_nb[i] <= r_rd[3*CS_W + i*N_W +: N_W];
            end
            if (i_cmd.diff) begin
                r_cd[i] <= CD_W'(r_ca[i]) - CD_W'(r_cb[i]);
            end
            if (i_cmd.square) begin
                r_sq[i] <= r_cd[i] * r_cd[i];
            end
        end
        if (i_cmd.dsum) begin
            r_d2 <= D2_W'($unsigned(r_sq[0])) + D2_W'($unsigned(r_sq[1]))
                  + D2_W'($unsigned(r_sq[2]));
        end
    end

    assign w_lim9 = (LIM_W'(r_dist) << 3) + LIM_W'(r_dist);

    // angle binning
    logic [N_W-1:0]               w_mag_a [3];
    logic [N_W-1:0]               w_mag_b [3];
    logic signed [DT_W-1:0]       r_dt;
    logic [DT_W-1:0]              r_nsa, r_nsb;
    logic [DT_W-1:0]              w_dt_mag;
    logic [P_W-1:0]               r_p, r_dd;
    logic [arpe_pkg::BIN_W-1:0]   r_k, r_bin;
    logic [PR_W-1:0]              w_a;
    logic [DT_W-1:0]              w_b;
    logic                         w_mul_done;
    logic [PR_W-1:0]              w_prod;
    logic [DT_W-1:0]              w_prod_lo;
    logic                         w_sgn;
    logic                         w_cmp_le;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mag_a[i] = r_na[i][N_W-1] ? N_W'(-r_na[i]) : N_W'(r_na[i]);
            w_mag_b[i] = r_nb[i][N_W-1] ? N_W'(-r_nb[i]) : N_W'(r_nb[i]);
        end
        w_dt_mag = r_dt[DT_W-1] ? DT_W'(-r_dt) : DT_W'(r_dt);
    end

    always_comb begin
        w_sgn = 1'b0;
        case (i_cmd.op)
            arpe_pkg::OP_DOT_X: begin
                w_a = PR_W'(w_mag_a[0]); w_b = DT_W'(w_mag_b[0]);
                w_sgn = r_na[0][N_W-1] ^ r_nb[0][N_W-1];
            end
            arpe_pkg::OP_DOT_Y: begin
                w_a = PR_W'(w_mag_a[1]); w_b = DT_W'(w_mag_b[1]);
                w_sgn = r_na[1][N_W-1] ^ r_nb[1][N_W-1];
            end
            arpe_pkg::OP_DOT_Z: begin
                w_a = PR_W'(w_mag_a[2]); w_b = DT_W'(w_mag_b[2]);
                w_sgn = r_na[2][N_W-1] ^ r_nb[2][N_W-1];
            end
            arpe_pkg::OP_NA_X: begin w_a = PR_W'(w_mag_a[0]); w_b = DT_W'(w_mag_a[0]); end
            arpe_pkg::OP_NA_Y: begin w_a = PR_W'(w_mag_a[1]); w_b = DT_W'(w_mag_a[1]); end
            arpe_pkg::OP_NA_Z: begin w_a = PR_W'(w_mag_a[2]); w_b = DT_W'(w_mag_a[2]); end
            arpe_pkg::OP_NB_X: begin w_a = PR_W'(w_mag_b[0]); w_b = DT_W'(w_mag_b[0]); end
            arpe_pkg::OP_NB_Y: begin w_a = PR_W'(w_mag_b[1]); w_b = DT_W'(w_mag_b[1]); end
            arpe_pkg::OP_NB_Z: begin w_a = PR_W'(w_mag_b[2]); w_b = DT_W'(w_mag_b[2]); end
            arpe_pkg::OP_P:    begin w_a = PR_W'(r_nsa); w_b = r_nsb; end
            arpe_pkg::OP_D:    begin w_a = PR_W'(w_dt_mag); w_b = w_dt_mag; end
            default: begin
                w_a = PR_W'(r_p);
                w_b = DT_W'(arpe_pkg::cos2_thr(r_k));
            end
        endcase
    end

    arpe_mul #(
        .PR_W (PR_W),
        .B_W  (DT_W)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    assign w_prod_lo = w_prod[DT_W-1:0];
    // d * 2^32 against c[k] * p
    assign w_cmp_le  = ({r_dd, arpe_pkg::CTHR_W'(0)} <= w_prod);

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_a) begin
            r_dt  <= '0;
            r_nsa <= '0;
            r_nsb <= '0;
            r_k   <= arpe_pkg::BIN_FIRST;
            r_bin <= '0;
        end else if (i_cmd.mul_take) begin
            case (i_cmd.op)
                arpe_pkg::OP_DOT_X, arpe_pkg::OP_DOT_Y, arpe_pkg::OP_DOT_Z: begin
                    r_dt <= w_sgn ? r_dt - $signed(w_prod_lo) : r_dt + $signed(w_prod_lo);
                end
                arpe_pkg::OP_NA_X, arpe_pkg::OP_NA_Y, arpe_pkg::OP_NA_Z: begin
                    r_nsa <= r_nsa + w_prod_lo;
                end
                arpe_pkg::OP_NB_X, arpe_pkg::OP_NB_Y, arpe_pkg::OP_NB_Z: begin
                    r_nsb <= r_nsb + w_prod_lo;
                end
                arpe_pkg::OP_P: r_p  <= w_prod[P_W-1:0];
                arpe_pkg::OP_D: r_dd <= w_prod[P_W-1:0];
                default: begin
                    if (w_cmp_le) begin
                        r_bin <= r_k;
                    end
                    r_k <= r_k + arpe_pkg::BIN_W'(1);
                end
            endcase
        end
    end

    // energy sum
    logic [arpe_pkg::BIN_W-1:0] w_bin;
    logic signed [WW-1:0]       w_word;
    logic signed [EW-1:0]       r_sum;
    logic [arpe_pkg::PAIRS_W-1:0] r_pairs;

    // a zero normal counts as the top bin
    assign w_bin = (r_p == '0) ? arpe_pkg::BIN_MAX : r_bin;

    always_comb begin
        case (w_bin)
            4'd0:    w_word = r_bins_low[0*WW +: WW];
            4'd1:    w_word = r_bins_low[1*WW +: WW];
            4'd2:    w_word = r_bins_low[2*WW +: WW];
            4'd3:    w_word = r_bins_low[3*WW +: WW];
            4'd4:    w_word = r_bins_high[0*WW +: WW];
            4'd5:    w_word = r_bins_high[1*WW +: WW];
            4'd6:    w_word = r_bins_high[2*WW +: WW];
            4'd7:    w_word = r_bins_high[3*WW +: WW];
            default: w_word = r_bin_last;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_init) begin
            r_sum   <= '0;
            r_pairs <= '0;
        end else if (i_cmd.add_pair) begin
            r_sum   <= r_sum + EW'(w_word);
            r_pairs <= r_pairs + arpe_pkg::PAIRS_W'(1);
        end
    end

    // result register
    logic                         r_out_valid;
    logic signed [EW-1:0]         r_out_e;
    logic [arpe_pkg::PAIRS_W-1:0] r_out_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_e <= r_sum;
            r_out_p <= r_pairs;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_energy_milli = r_out_e;
    assign o_close_pairs  = r_out_p;

    assign o_sts.last      = r_last;
    assign o_sts.few       = (r_cnt < CW'(2));
    assign o_sts.close     = (CMP_W'(r_d2) < CMP_W'(w_lim9));
    assign o_sts.mul_done  = w_mul_done;
    assign o_sts.p_zero    = (r_p == '0);
    assign o_sts.cmp_le    = w_cmp_le;
    assign o_sts.k_last    = (r_k == arpe_pkg::BIN_MAX);
    assign o_sts.pair_last = (CW'(r_r1) + CW'(2) == r_cnt) && (CW'(r_r2) + CW'(1) == r_cnt);
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;
endmodule

### hdl/arpe_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpe_ctrl
// Sequencer for ring load, pair walk, angle test and result hand-off.
// ----------------------------------------------------------------------------
module arpe_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output arpe_pkg::t_cmd o_cmd,
    input  arpe_pkg::t_sts i_sts
);
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_LX   = 5'd1;
    localparam logic [4:0] S_LY   = 5'd2;
    localparam logic [4:0] S_LZ   = 5'd3;
    localparam logic [4:0] S_LW   = 5'd4;
    localparam logic [4:0] S_ST   = 5'd5;
    localparam logic [4:0] S_WI   = 5'd6;
    localparam logic [4:0] S_RA   = 5'd7;
    localparam logic [4:0] S_RB   = 5'd8;
    localparam logic [4:0] S_LB   = 5'd9;
    localparam logic [4:0] S_DF   = 5'd10;
    localparam logic [4:0] S_SQ   = 5'd11;
    localparam logic [4:0] S_SM   = 5'd12;
    localparam logic [4:0] S_CP   = 5'd13;
    localparam logic [4:0] S_MG   = 5'd14;
    localparam logic [4:0] S_MW   = 5'd15;
    localparam logic [4:0] S_AD   = 5'd16;
    localparam logic [4:0] S_NX   = 5'd17;
    localparam logic [4:0] S_EM   = 5'd18;

    logic [4:0]                r_state, n_state;
    logic [arpe_pkg::OP_W-1:0] r_op, n_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= arpe_pkg::OP_DOT_X;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        o_cmd   = '0;
        o_cmd.op = r_op;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = S_LX;
                end
            end
            S_LX: begin
                o_cmd.mul_en = 1'b1; o_cmd.mul_sel = arpe_pkg::AX_X;
                n_state = S_LY;
            end
            S_LY: begin
                o_cmd.mul_en = 1'b1; o_cmd.mul_sel = arpe_pkg::AX_Y;
                o_cmd.sub_en = 1'b1; o_cmd.sub_sel = arpe_pkg::AX_X;
                n_state = S_LZ;
            end
            S_LZ: begin
                o_cmd.mul_en = 1'b1; o_cmd.mul_sel = arpe_pkg::AX_Z;
                o_cmd.sub_en = 1'b1; o_cmd.sub_sel = arpe_pkg::AX_Y;
                n_state = S_LW;
            end
            S_LW: begin
                o_cmd.sub_en = 1'b1; o_cmd.sub_sel = arpe_pkg::AX_Z;
                n_state = S_ST;
            end
            S_ST: begin
                o_cmd.store = 1'b1;
                n_state = i_sts.last ? S_WI : S_IDLE;
            end
            S_WI: begin
                o_cmd.walk_init = 1'b1;
                n_state = i_sts.few ? S_EM : S_RA;
            end
            S_RA: begin
                o_cmd.rd_en = 1'b1;
                n_state = S_RB;
            end
            S_RB: begin
                o_cmd.latch_a = 1'b1;
                o_cmd.rd_en = 1'b1; o_cmd.rd_second = 1'b1;
                n_state = S_LB;
            end
            S_LB: begin
                o_cmd.latch_b = 1'b1;
                n_state = S_DF;
            end
            S_DF: begin
                o_cmd.diff = 1'b1;
                n_state = S_SQ;
            end
            S_SQ: begin
                o_cmd.square = 1'b1;
                n_state = S_SM;
            end
            S_SM: begin
                o_cmd.dsum = 1'b1;
                n_state = S_CP;
            end
            S_CP: begin
                if (i_sts.close) begin
                    n_op = arpe_pkg::OP_DOT_X;
                    n_state = S_MG;
                end else begin
                    n_state = S_NX;
                end
            end
            S_MG: begin
                o_cmd.mul_start = 1'b1;
                n_state = S_MW;
            end
            S_MW: begin
                if (i_sts.mul_done) begin
                    o_cmd.mul_take = 1'b1;
                    if (r_op == arpe_pkg::OP_D) begin
                        if (i_sts.p_zero) begin
                            n_state = S_AD;
                        end else begin
                            n_op = arpe_pkg::OP_C;
                            n_state = S_MG;
                        end
                    end else if (r_op == arpe_pkg::OP_C) begin
                        // thresholds fall with k, so the first miss ends the search
                        n_state = (!i_sts.cmp_le || i_sts.k_last) ? S_AD : S_MG;
                    end else begin
                        n_op = r_op + arpe_pkg::OP_W'(1);
                        n_state = S_MG;
                    end
                end
            end
            S_AD: begin
                o_cmd.add_pair = 1'b1;
                n_state = S_NX;
            end
            S_NX: begin
                if (i_sts.pair_last) begin
                    n_state = S_EM;
                end else begin
                    o_cmd.next_pair = 1'b1;
                    n_state = S_RA;
                end
            end
            S_EM: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

### hdl/aromatic_ring_pair_energy_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aromatic_ring_pair_energy_core
// Ring-pair stacking energy: stores ring centres and normals, then on the
// last ring sums binned energy words over all close ring pairs.
// ----------------------------------------------------------------------------
//  channel | handshake                | payload
//  --------+--------------------------+-----------------------------------
//  in      | i_in_valid / o_in_stall  | i_base_*, i_second_*, i_third_*,
//          |                          | i_last_ring
//  out     | o_out_valid / i_out_stall| o_energy_milli, o_close_pairs
//  cfg     | i_cfg_we                 | i_cfg_index, i_cfg_data
//
//  a ring load computes the cross product through two 19x19 multipliers
//  in the walk a close pair adds 11 to 19 passes of the shift-add
//  multiplier, whose multiplier operand has B = 4*COORD_WIDTH+8 bits
//  (80 at defaults), so these passes set the walk time
//  synchronous active-low reset; ring store needs no clearing
//  a finished word waits in the result register while the next ring loads
module aromatic_ring_pair_energy_core #(
    parameter int MAX_RINGS   = arpe_pkg::MAX_RINGS_DEF,
    parameter int COORD_WIDTH = arpe_pkg::COORD_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic signed [COORD_WIDTH-1:0]          i_base_x,
    input  logic signed [COORD_WIDTH-1:0]          i_base_y,
    input  logic signed [COORD_WIDTH-1:0]          i_base_z,
    input  logic signed [COORD_WIDTH-1:0]          i_second_x,
    input  logic signed [COORD_WIDTH-1:0]          i_second_y,
    input  logic signed [COORD_WIDTH-1:0]          i_second_z,
    input  logic signed [COORD_WIDTH-1:0]          i_third_x,
    input  logic signed [COORD_WIDTH-1:0]          i_third_y,
    input  logic signed [COORD_WIDTH-1:0]          i_third_z,
    input  logic                                   i_last_ring,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [arpe_pkg::ENERGY_W-1:0]   o_energy_milli,
    output logic [arpe_pkg::PAIRS_W-1:0]           o_close_pairs,
    input  logic                                   i_cfg_we,
    input  logic [arpe_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [arpe_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    arpe_pkg::t_cmd w_cmd;
    arpe_pkg::t_sts w_sts;

    arpe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    arpe_dp #(
        .MAX_RINGS   (MAX_RINGS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_base_x       (i_base_x),
        .i_base_y       (i_base_y),
        .i_base_z       (i_base_z),
        .i_second_x     (i_second_x),
        .i_second_y     (i_second_y),
        .i_second_z     (i_second_z),
        .i_third_x      (i_third_x),
        .i_third_y      (i_third_y),
        .i_third_z      (i_third_z),
        .i_last_ring    (i_last_ring),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_energy_milli (o_energy_milli),
        .o_close_pairs  (o_close_pairs),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

`ifndef SYNTHESIS
    a_take_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.mul_take |-> w_sts.mul_done)
        else $error("product taken before the multiplier finished");

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.accept |-> !o_in_stall)
        else $error("word loaded while the input is stalled");

    a_emit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result raised without a walk in progress");
`endif
endmodule
